FILE: rtl/bounded_ordered_list_engine_core_macros.svh
// Assertion macros used by the list engine top level.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_CORE_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BOLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BOLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bole_pkg.sv
// Shared types and constants of the list engine.
package bole_pkg;

   localparam int ValueWidth      = 32;
   localparam int PositionWidth   = 8;
   localparam int IndexWidth      = 4;
   localparam int CountWidth      = 5;
   localparam int DefaultCapacity = 16;

   typedef enum logic [2:0] {
      REQ_FRONT    = 3'd0,
      REQ_APPEND   = 3'd1,
      REQ_INSERT   = 3'd2,
      REQ_DELETE   = 3'd3,
      REQ_SEARCH   = 3'd4,
      REQ_DUMP_FWD = 3'd5,
      REQ_DUMP_BWD = 3'd6,
      REQ_CLEAR    = 3'd7
   } bole_req_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_MISS  = 2'd2,
      ST_EMPTY = 2'd3
   } bole_status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_MATCH,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROT_L,
      CELL_ROT_R
   } bole_cell_op_type;

   typedef struct packed {
      bole_cell_op_type        op;
      logic [ValueWidth-1:0]   key;
   } bole_cell_cmd_type;

endpackage

FILE: rtl/bole_cell.sv
// One storage cell of the list chain: holds one entry and trades it with its neighbours.
module bole_cell
   import bole_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CW    = 5
) (
   input  logic                  clock,
   input  bole_cell_cmd_type     cmd,
   input  logic [CW-1:0]         at_idx,
   input  logic [CW-1:0]         count,
   input  logic                  take_right,
   input  logic [ValueWidth-1:0] left_data,
   input  logic [ValueWidth-1:0] right_data,
   input  logic [ValueWidth-1:0] wrap_data,
   output logic [ValueWidth-1:0] data,
   output logic                  match
);

   localparam logic [CW-1:0] MyIdx = CW'(INDEX);

   logic [ValueWidth-1:0] data_ff, data_in;
   logic                  match_ff, match_in;
   logic [CW-1:0]         last_idx;

   assign last_idx = count - CW'(1);

   always_comb begin
      data_in  = data_ff;
      match_in = match_ff;
      case (cmd.op)
         CELL_MATCH: begin
            // Only occupied places may report a hit.
            match_in = (data_ff == cmd.key) && (MyIdx < count);
         end
         CELL_INSERT: begin
            if (MyIdx == at_idx) begin
               data_in = cmd.key;
            end else if (MyIdx > at_idx) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (take_right) begin
               data_in = right_data;
            end
         end
         CELL_ROT_L: begin
            if (MyIdx < last_idx) begin
               data_in = right_data;
            end else if (MyIdx == last_idx) begin
               data_in = wrap_data;
            end
         end
         CELL_ROT_R: begin
            if (MyIdx == '0) begin
               data_in = wrap_data;
            end else if (MyIdx < count) begin
               data_in = left_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

FILE: rtl/bole_scan.sv
// Parallel prefix scan over the cell hit flags: first hit and its index.
module bole_scan
   import bole_pkg::*;
#(
   parameter int N  = 16,
   parameter int IW = 4
) (
   input  logic [N-1:0]  hits,
   output logic [N-1:0]  upto,
   output logic          any_hit,
   output logic [IW-1:0] first_idx
);

   localparam int Levels = $clog2(N);

   logic [Levels:0][N-1:0] lvl;
   logic [N-1:0]           first_hot;

   assign lvl[0] = hits;

   for (genvar k = 0; k < Levels; k++) begin : g_level
      for (genvar i = 0; i < N; i++) begin : g_bit
         if (i >= (1 << k)) begin : g_merge
            assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1<<k)];
         end else begin : g_pass
            assign lvl[k+1][i] = lvl[k][i];
         end
      end
   end

   // upto[i] is set when some place at or below i hits.
   assign upto      = lvl[Levels];
   assign any_hit   = upto[N-1];
   assign first_hot = hits & ~{upto[N-2:0], 1'b0};

   always_comb begin
      first_idx = '0;
      for (int i = 0; i < N; i++) begin
         first_idx = first_idx | (IW'(i) & {IW{first_hot[i]}});
      end
   end

endmodule

FILE: rtl/bounded_ordered_list_engine_core.sv
// Top level of the ordered list engine: request control, cell chain and response register.
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_stall   req_type, req_value, req_position
//   rsp_      out         rsp_valid / rsp_stall   rsp_status, rsp_entry_value,
//                                                 rsp_entry_index, rsp_entry_count,
//                                                 rsp_last_result
//
// An insert, delete, search or clear is captured in S_IDLE, where every cell compares against
// the value; S_EXEC then shifts the chain for an insert or delete and writes the response.
// A dump goes on from S_EXEC to S_DUMP, which rotates the chain one place per entry answered.
// Reset clears the entry count and control; entry contents are left as they are.
// A stalled response holds the engine; a new request is taken once the previous one is done.
`include "bounded_ordered_list_engine_core_macros.svh"

module bounded_ordered_list_engine_core
   import bole_pkg::*;
#(
   parameter int CAPACITY = DefaultCapacity
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_type,
   input  logic signed [ValueWidth-1:0] req_value,
   input  logic [PositionWidth-1:0]     req_position,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic signed [ValueWidth-1:0] rsp_entry_value,
   output logic [IndexWidth-1:0]        rsp_entry_index,
   output logic [CountWidth-1:0]        rsp_entry_count,
   output logic                         rsp_last_result
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int IW   = $clog2(CAPACITY);
   localparam int CMPW = (CW > PositionWidth) ? CW : PositionWidth;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DUMP
   } state_type;

   state_type               state_ff, state_in;
   bole_req_type            op_ff, op_in;
   logic [ValueWidth-1:0]   value_ff, value_in;
   logic [PositionWidth-1:0] position_ff, position_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   bole_status_type         rsp_status_ff, rsp_status_in;
   logic [ValueWidth-1:0]   rsp_value_ff, rsp_value_in;
   logic [IndexWidth-1:0]   rsp_index_ff, rsp_index_in;
   logic [CountWidth-1:0]   rsp_count_ff, rsp_count_in;
   logic                    rsp_last_ff, rsp_last_in;

   bole_cell_cmd_type       cmd;
   logic [CW-1:0]           at_idx;
   logic [CW-1:0]           tail_idx;
   logic [CW-1:0]           res_idx;
   logic [CW-1:0]           res_count;
   logic [IW+IndexWidth-1:0] idx_wide;
   logic [CW+CountWidth-1:0] cnt_wide;
   logic                    out_free;
   logic                    list_full;
   logic                    is_insert;
   logic                    dump_fwd;
   logic [CMPW-1:0]         pos_ext;
   logic [CMPW-1:0]         cnt_ext;
   logic [ValueWidth-1:0]   tail_data;
   logic [ValueWidth-1:0]   wrap_data;
   logic [ValueWidth-1:0]   cell_data  [CAPACITY];
   logic [ValueWidth-1:0]   left_data  [CAPACITY];
   logic [ValueWidth-1:0]   right_data [CAPACITY];
   logic [CAPACITY-1:0]     hit_vec;
   logic [CAPACITY-1:0]     hit_upto;
   logic                    any_hit;
   logic [IW-1:0]           first_idx;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign list_full = (count_ff == CW'(CAPACITY));
   assign tail_idx  = count_ff - CW'(1);
   assign dump_fwd  = (op_ff == REQ_DUMP_FWD);
   assign is_insert = (op_ff == REQ_FRONT) || (op_ff == REQ_APPEND) ||
                      (op_ff == REQ_INSERT);

   // Insert place: a position past the end appends.
   assign pos_ext = CMPW'(position_ff);
   assign cnt_ext = CMPW'(count_ff);
   always_comb begin
      case (op_ff)
         REQ_FRONT:  at_idx = '0;
         REQ_INSERT: at_idx = (pos_ext >= cnt_ext) ? count_ff : pos_ext[CW-1:0];
         default:    at_idx = count_ff;
      endcase
   end

   // The tail entry is picked out by an AND-OR over the cells for a backward dump.
   always_comb begin
      tail_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_data = tail_data | (cell_data[i] & {ValueWidth{CW'(i) == tail_idx}});
      end
   end

   assign wrap_data = dump_fwd ? cell_data[0] : tail_data;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_data[g] = '0;
      end else begin : g_body
         assign left_data[g] = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_end
         assign right_data[g] = '0;
      end else begin : g_mid
         assign right_data[g] = cell_data[g+1];
      end

      bole_cell #(
         .INDEX (g),
         .CW    (CW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .at_idx     (at_idx),
         .count      (count_ff),
         .take_right (hit_upto[g]),
         .left_data  (left_data[g]),
         .right_data (right_data[g]),
         .wrap_data  (wrap_data),
         .data       (cell_data[g]),
         .match      (hit_vec[g])
      );
   end

   bole_scan #(
      .N  (CAPACITY),
      .IW (IW)
   ) u_scan (
      .hits      (hit_vec),
      .upto      (hit_upto),
      .any_hit   (any_hit),
      .first_idx (first_idx)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      position_in   = position_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      cmd.op        = CELL_HOLD;
      cmd.key       = value_ff;
      res_idx       = '0;
      res_count     = count_ff;

      unique case (state_ff)
         S_IDLE: begin
            cmd.key = req_value;
            if (req_valid) begin
               cmd.op      = CELL_MATCH;
               op_in       = bole_req_type'(req_type);
               value_in    = req_value;
               position_in = req_position;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_value_in = '0;
               state_in     = S_IDLE;
               if (is_insert) begin
                  if (list_full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     cmd.op        = CELL_INSERT;
                     res_count     = count_ff + CW'(1);
                     rsp_status_in = ST_OK;
                  end
               end else if ((op_ff == REQ_DELETE) || (op_ff == REQ_SEARCH)) begin
                  if (any_hit) begin
                     rsp_status_in = ST_OK;
                     rsp_value_in  = value_ff;
                     if (op_ff == REQ_DELETE) begin
                        cmd.op    = CELL_DELETE;
                        res_count = count_ff - CW'(1);
                     end else begin
                        res_idx = CW'(first_idx);
                     end
                  end else begin
                     rsp_status_in = ST_MISS;
                  end
               end else if (op_ff == REQ_CLEAR) begin
                  res_count     = '0;
                  rsp_status_in = ST_OK;
               end else begin
                  // Dump: an empty list answers at once, otherwise walk the chain.
                  if (count_ff == '0) begin
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                     step_in      = '0;
                     state_in     = S_DUMP;
                  end
               end
               count_in = res_count;
            end
         end
         S_DUMP: begin
            if (out_free) begin
               cmd.op        = dump_fwd ? CELL_ROT_L : CELL_ROT_R;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_value_in  = dump_fwd ? cell_data[0] : tail_data;
               res_idx       = dump_fwd ? step_ff : (tail_idx - step_ff);
               rsp_last_in   = (step_ff == tail_idx);
               step_in       = step_ff + CW'(1);
               if (step_ff == tail_idx) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_valid_in && !(rsp_valid_ff && rsp_stall)) begin
         idx_wide     = {{IndexWidth{1'b0}}, res_idx[IW-1:0]};
         cnt_wide     = {{CountWidth{1'b0}}, res_count};
         rsp_index_in = idx_wide[IndexWidth-1:0];
         rsp_count_in = cnt_wide[CountWidth-1:0];
      end else begin
         idx_wide = '0;
         cnt_wide = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      value_ff      <= value_in;
      position_ff   <= position_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = $signed(rsp_value_ff);
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last_result = rsp_last_ff;

   `BOLE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "count above capacity")
   `BOLE_ASSERT_NOW(a_dump_nonempty, clock, reset, state_ff == S_DUMP, count_ff != '0, "dump of empty list")
   `BOLE_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && !req_stall, state_ff == S_EXEC, "request not executed")
   `BOLE_ASSERT_NEXT(a_insert_grows, clock, reset, state_ff == S_EXEC && out_free && is_insert && !list_full, count_ff == $past(count_ff) + CW'(1), "insert did not grow list")

endmodule
